>>> design/atrp_pkg.sv
// Package for the accelerometer tilt block: widths, pipeline depths, the CORDIC
// arctangent table and the types passed between the lane and its cells.
// No dependencies.
package atrp_pkg;

  localparam int DATA_W      = 16;
  localparam int AXIS_W      = 17;
  localparam int NUM_W       = 18;
  localparam int MAG_W       = 17;
  localparam int SUMSQ_W     = 34;
  localparam int SQ_W        = 64;
  localparam int NORM_W      = 32;
  localparam int XY_W        = 35;
  localparam int Z_W         = 32;
  localparam int ACC_FRAC    = 24;
  localparam int SQRT_STEPS  = 32;
  localparam int NORM_STEPS  = 5;
  localparam int CORDIC_STEPS = 28;
  localparam int LANE_LAT    = SQRT_STEPS + NORM_STEPS + CORDIC_STEPS;
  localparam int PRE_LAT     = 3;
  localparam int PIPE_DEPTH  = PRE_LAT + LANE_LAT;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_OFFSET_X = 2'd0;
  localparam reg_index_t REG_OFFSET_Y = 2'd1;
  localparam reg_index_t REG_OFFSET_Z = 2'd2;

  // 90 degrees with 24 fraction bits.
  localparam logic signed [Z_W-1:0] Z_MAX = 32'sd1509949440;

  // atan(2^-i) in degrees with 24 fraction bits.
  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489089, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115,
    32'sd57,        32'sd29,        32'sd14,        32'sd7
  };

  // Per-item side information that travels beside the datapath.
  typedef struct packed {
    logic             neg;
    logic             num_zero;
    logic             den_zero;
    logic [MAG_W-1:0] mag;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

endpackage

>>> design/atrp_sqrt_cell.sv
// One cell of the pipelined integer square root: settles one result bit.
// Depends on atrp_pkg.
module atrp_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [atrp_pkg::SQ_W-1:0] v_in,
  input  logic [atrp_pkg::SQ_W-1:0] res_in,
  output logic [atrp_pkg::SQ_W-1:0] v,
  output logic [atrp_pkg::SQ_W-1:0] res
);
  import atrp_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

  logic [SQ_W-1:0] trial;
  assign trial = res_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= trial) begin
        v   <= v_in - trial;
        res <= (res_in >> 1) + BIT;
      end else begin
        v   <= v_in;
        res <= res_in >> 1;
      end
    end
  end

endmodule

>>> design/atrp_cordic_cell.sv
// One vectoring step of the CORDIC arctangent chain.
// Depends on atrp_pkg.
module atrp_cordic_cell #(
  parameter int I = 0
) (
  input  logic              clk,
  input  logic              en,
  input  atrp_pkg::cordic_t d,
  output atrp_pkg::cordic_t q
);
  import atrp_pkg::*;

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign xs = d.x >>> I;
  assign ys = d.y >>> I;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!d.y[XY_W-1]) begin
        q.x <= d.x + ys;
        q.y <= d.y - xs;
        q.z <= d.z + ATAN_TAB[I];
      end else begin
        q.x <= d.x - ys;
        q.y <= d.y + xs;
        q.z <= d.z - ATAN_TAB[I];
      end
    end
  end

endmodule

>>> design/atrp_lane.sv
// One angle lane: square root chain, normalizing shifts, CORDIC chain and
// final clamp, rounding and saturation. Depends on atrp_pkg and the two cells.
module atrp_lane #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [atrp_pkg::NUM_W-1:0]  num,
  input  logic [atrp_pkg::SUMSQ_W-1:0]       sumsq,
  output logic signed [atrp_pkg::DATA_W-1:0] angle,
  output logic                               undef
);
  import atrp_pkg::*;

  localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;

  side_t side_in;
  side_t side_d [LANE_LAT];

  logic [SQ_W-1:0]   sq_v   [SQRT_STEPS+1];
  logic [SQ_W-1:0]   sq_res [SQRT_STEPS+1];
  logic [NORM_W-1:0] nx     [NORM_STEPS+1];
  logic [NORM_W-1:0] ny     [NORM_STEPS+1];
  cordic_t           cs     [CORDIC_STEPS+1];

  logic [NUM_W-1:0] num_abs;
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  assign side_in.neg      = num[NUM_W-1];
  assign side_in.num_zero = (num == '0);
  assign side_in.den_zero = (sumsq == '0);
  assign side_in.mag      = num_abs[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_in;
      for (int i = 1; i < LANE_LAT; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  // Root of sumsq with 14 fraction bits.
  assign sq_v[0]   = SQ_W'(sumsq) << 28;
  assign sq_res[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    atrp_sqrt_cell #(.K(SQRT_STEPS - 1 - k)) u_cell (
      .clk    (clk),
      .en     (en),
      .v_in   (sq_v[k]),
      .res_in (sq_res[k]),
      .v      (sq_v[k+1]),
      .res    (sq_res[k+1])
    );
  end

  // Shift both operands left until the larger reaches bit 30.
  assign nx[0] = sq_res[SQRT_STEPS][NORM_W-1:0];
  assign ny[0] = {1'b0, side_d[SQRT_STEPS-1].mag, 14'b0};

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int S = 16 >> k;
    always_ff @(posedge clk) begin
      if (en) begin
        if ((nx[k] | ny[k]) < (NORM_W'(1) << (31 - S))) begin
          nx[k+1] <= nx[k] << S;
          ny[k+1] <= ny[k] << S;
        end else begin
          nx[k+1] <= nx[k];
          ny[k+1] <= ny[k];
        end
      end
    end
  end

  assign cs[0].x = signed'({3'b000, nx[NORM_STEPS]});
  assign cs[0].y = signed'({3'b000, ny[NORM_STEPS]});
  assign cs[0].z = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    atrp_cordic_cell #(.I(k)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (cs[k]),
      .q   (cs[k+1])
    );
  end

  // Clamp, round half up, apply sign and saturate to the field.
  side_t                  side_o;
  logic signed [Z_W-1:0]  zc;
  logic [Z_W-1:0]         rnd;
  logic signed [Z_W-1:0]  mag;
  logic signed [Z_W-1:0]  sgn;

  assign side_o = side_d[LANE_LAT-1];

  always_comb begin
    zc = cs[CORDIC_STEPS].z;
    if (zc < 0) begin
      zc = '0;
    end else if (zc > Z_MAX) begin
      zc = Z_MAX;
    end
    rnd = unsigned'(zc) + (Z_W'(1) << (SH - 1));
    if (side_o.den_zero) begin
      mag = signed'(Z_W'(90) << ANGLE_FRAC_BITS);
    end else begin
      mag = signed'(rnd >> SH);
    end
    sgn = side_o.neg ? -mag : mag;
    undef = side_o.den_zero && side_o.num_zero;
    if (undef) begin
      angle = '0;
    end else if (sgn > 32'sd32767) begin
      angle = 16'sh7fff;
    end else if (sgn < -32'sd32768) begin
      angle = 16'sh8000;
    end else begin
      angle = sgn[DATA_W-1:0];
    end
  end

endmodule

>>> design/accel_tilt_roll_pitch_top.sv
// Accelerometer tilt block: roll and pitch in degrees from one X/Y/Z item.
// The path is 68 register stages (offset add, squaring, sum, 32 root cells, 5 shift
// stages, 28 CORDIC cells) plus the output register. Throughput is one item per cycle
// while the skid register is empty; a full skid stalls the whole pipeline.
// Synchronous active-high rst restores the offset registers and empties the pipeline.
module accel_tilt_roll_pitch_top #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // raw_x [15:0], raw_y [31:16], raw_z [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // roll_deg [15:0], pitch_deg [31:16]
  output logic [1:0]  m_tuser,   // roll_undefined [0], pitch_undefined [1]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import atrp_pkg::*;

  // Calibration offsets, in raw sensor counts.
  logic signed [DATA_W-1:0] offset_x;
  logic signed [DATA_W-1:0] offset_y;
  logic signed [DATA_W-1:0] offset_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= 16'sd1219;
      offset_y <= -16'sd122;
      offset_z <= 16'sd569;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_OFFSET_Z: offset_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless the skid register holds an
  // item; the skid lets one more item drain while the output is stalled.
  logic skid_valid;
  logic en;
  logic [PIPE_DEPTH-1:0] vpipe;

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  // Stage A: offsets added at full 17-bit width.
  logic signed [AXIS_W-1:0] ax, ay, az;
  logic signed [DATA_W-1:0] raw_x, raw_y, raw_z;

  assign raw_x = s_tdata[15:0];
  assign raw_y = s_tdata[31:16];
  assign raw_z = s_tdata[47:32];

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= AXIS_W'(raw_x) + AXIS_W'(offset_x);
      ay <= AXIS_W'(raw_y) + AXIS_W'(offset_y);
      az <= AXIS_W'(raw_z) + AXIS_W'(offset_z);
    end
  end

  // Stage B: squares.
  logic signed [2*AXIS_W-1:0] px, py, pz;
  logic [SUMSQ_W-1:0]         sqx, sqy, sqz;
  logic signed [AXIS_W-1:0]   bx, by;

  assign px = ax * ax;
  assign py = ay * ay;
  assign pz = az * az;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= unsigned'(px);
      sqy <= unsigned'(py);
      sqz <= unsigned'(pz);
      bx  <= ax;
      by  <= ay;
    end
  end

  // Stage C: sums of squares and signed numerators for both angles.
  logic [SUMSQ_W-1:0]      sum_roll, sum_pitch;
  logic signed [NUM_W-1:0] num_roll, num_pitch;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_roll  <= sqx + sqz;
      sum_pitch <= sqy + sqz;
      num_roll  <= NUM_W'(by);
      num_pitch <= -NUM_W'(bx);
    end
  end

  logic signed [DATA_W-1:0] roll_deg, pitch_deg;
  logic                     roll_undefined, pitch_undefined;

  atrp_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
    .clk   (clk),
    .en    (en),
    .num   (num_roll),
    .sumsq (sum_roll),
    .angle (roll_deg),
    .undef (roll_undefined)
  );

  atrp_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
    .clk   (clk),
    .en    (en),
    .num   (num_pitch),
    .sumsq (sum_pitch),
    .angle (pitch_deg),
    .undef (pitch_undefined)
  );

  // Output register with a one-item skid stage behind it.
  logic        tail_take;
  logic [31:0] skid_data;
  logic [1:0]  skid_user;

  assign tail_take = vpipe[PIPE_DEPTH-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= tail_take;
      end
    end else if (tail_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= {pitch_deg, roll_deg};
        m_tuser <= {pitch_undefined, roll_undefined};
      end
    end else if (tail_take) begin
      skid_data <= {pitch_deg, roll_deg};
      skid_user <= {pitch_undefined, roll_undefined};
    end
  end

  // The skid stage only fills behind a waiting output item.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds an item while the output register is empty");

  // A roll angle flagged undefined is always reported as zero.
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] == 16'h0000))
    else $error("roll flagged undefined with a nonzero angle");

  // A stalled output with a full skid keeps the skid full and input closed.
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> (skid_valid && !s_tready))
    else $error("skid item lost during output stall");

endmodule

>>> verif/accel_tilt_roll_pitch_top_tb.sv
// Testbench for the accelerometer tilt block: drives raw X/Y/Z items on the input
// stream, predicts roll, pitch and the undefined flags in a local model and checks them.
// Depends on atrp_pkg and accel_tilt_roll_pitch_top.
module accel_tilt_roll_pitch_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atrp_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = 69;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic       pitch_undef;
    logic       roll_undef;
    logic [15:0] pitch;
    logic [15:0] roll;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  accel_tilt_roll_pitch_top #(.ANGLE_FRAC_BITS(FRAC)) dut (.*);

  always #10 clk = ~clk;

  // Local copy of the offset registers.
  int off_x, off_y, off_z;
  angles_t pending_angles[$];
  int errors = 0;
  int idle_cycles = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_sink = 1'b0;

  // Bitwise integer square root, the classic two-bits-per-step form.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // One angle: atan(num / sqrt(sumsq)) in degrees with FRAC fraction bits.
  function automatic longint tilt_angle(longint num, longint unsigned sumsq, output bit undef);
    longint x, y, z, mag, xs, ys;
    longint tab[CORDIC_STEPS];
    for (int i = 0; i < CORDIC_STEPS; i++) tab[i] = ATAN_TAB[i];
    undef = 1'b0;
    if (sumsq == 0) begin
      if (num == 0) begin
        undef = 1'b1;
        return 0;
      end
      mag = longint'(90) << FRAC;
      return (num < 0) ? -mag : mag;
    end
    x = longint'(int_sqrt(sumsq << 28));
    y = ((num < 0) ? -num : num) * (longint'(1) << 14);
    while (x < (longint'(1) << 30) && y < (longint'(1) << 30)) begin
      x *= 2;
      y *= 2;
    end
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;   // arithmetic shift is a floor shift
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += tab[i];
      end else begin
        x -= ys; y += xs; z -= tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << ACC_FRAC)) z = longint'(90) << ACC_FRAC;
    mag = (z + (longint'(1) << (ACC_FRAC - FRAC - 1))) >>> (ACC_FRAC - FRAC);
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic [15:0] sat16(longint a);
    if (a > 32767) a = 32767;
    if (a < -32768) a = -32768;
    return a[15:0];
  endfunction

  function automatic angles_t tilt_of_sample(logic [47:0] d);
    longint ax, ay, az;
    bit ru, pu;
    angles_t r;
    ax = longint'($signed(d[15:0])) + off_x;
    ay = longint'($signed(d[31:16])) + off_y;
    az = longint'($signed(d[47:32])) + off_z;
    r.roll = sat16(tilt_angle(ay, ax * ax + az * az, ru));
    r.pitch = sat16(tilt_angle(-ax, ay * ay + az * az, pu));
    r.roll_undef = ru;
    r.pitch_undef = pu;
    return r;
  endfunction

  // Sends one item; the expectation is queued at the accepting edge.
  task automatic send_sample(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rz, ry, rx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_angles.push_back(tilt_of_sample(s_tdata));
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_offset(reg_index_t idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_OFFSET_X: off_x = $signed(val);
      REG_OFFSET_Y: off_y = $signed(val);
      REG_OFFSET_Z: off_z = $signed(val);
      default: ;
    endcase
  endtask

  // Waits until every expected item has come back, so registers can change.
  task automatic drain();
    stop_sending();
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A sample of a typical magnitude, sometimes a full-range value.
  function automatic logic [15:0] rand_axis();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 16000)) - 8000);
  endfunction

  task automatic test_reset_offsets();
    // Offsets at reset values; zero axes, extremes and sign changes.
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7fff, 16'h0000);
    send_sample(16'd0, 16'd0, 16'd8129);
    send_sample(16'd8129, 16'd0, 16'd0);
    send_sample(-16'sd8129, 16'd0, 16'd0);
    // Cancel the offsets exactly: every corrected axis is zero.
    send_sample(-16'sd1219, 16'sd122, -16'sd569);
    drain();
  endtask

  task automatic test_zero_offsets();
    write_offset(REG_OFFSET_X, 16'd0);
    write_offset(REG_OFFSET_Y, 16'd0);
    write_offset(REG_OFFSET_Z, 16'd0);
    // Both numerator and denominator zero gives the undefined flags.
    send_sample(16'd0, 16'd0, 16'd0);
    // Zero denominator with a nonzero numerator gives exactly +-90.
    send_sample(16'd0, 16'd5, 16'd0);
    send_sample(16'd0, -16'sd5, 16'd0);
    send_sample(16'd7, 16'd0, 16'd0);
    send_sample(-16'sd7, 16'd0, 16'd0);
    send_sample(16'd1, 16'd1, 16'd1);
    send_sample(16'h8000, 16'h8000, 16'd0);
    send_sample(16'h7fff, 16'h0001, 16'h8000);
    send_sample(16'h0001, 16'h7fff, 16'h0000);
    drain();
  endtask

  task automatic test_extreme_offsets();
    // Corrected axes reach the full 17-bit range and must not wrap.
    write_offset(REG_OFFSET_X, 16'h7fff);
    write_offset(REG_OFFSET_Y, 16'h8000);
    write_offset(REG_OFFSET_Z, 16'h7fff);
    send_sample(16'h7fff, 16'h8000, 16'h7fff);
    send_sample(16'h8000, 16'h7fff, 16'h8001);
    send_sample(16'h8001, 16'h8000, 16'h8001);
    for (int i = 0; i < 60; i++) send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    drain();
    write_offset(REG_OFFSET_X, 16'h8000);
    write_offset(REG_OFFSET_Y, 16'h7fff);
    write_offset(REG_OFFSET_Z, 16'h8000);
    send_sample(16'h8000, 16'h7fff, 16'h8000);
    for (int i = 0; i < 60; i++) send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    drain();
  endtask

  task automatic test_random_offsets();
    for (int phase = 0; phase < 4; phase++) begin
      write_offset(REG_OFFSET_X, 16'($signed($urandom_range(0, 4000)) - 2000));
      write_offset(REG_OFFSET_Y, 16'($signed($urandom_range(0, 4000)) - 2000));
      write_offset(REG_OFFSET_Z, 16'($urandom));
      for (int i = 0; i < 80; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
      drain();
    end
  endtask

  task automatic test_backpressure();
    // The sink holds off long enough for the pipeline to fill and stall the input.
    hold_sink = 1'b1;
    for (int i = 0; i < 100; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
    drain();
  endtask

  task automatic test_full_rate();
    // Final stretch with no idling on either side.
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < 60; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
    drain();
  endtask

  // Sink side: random stalls, plus one long hold-off when requested.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 12);
        m_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Checks each accepted item against the oldest expectation.
  always @(posedge clk) begin
    angles_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected item %h", $realtime, got);
        errors++;
      end else begin
        want = pending_angles.pop_front();
        if (got.roll !== want.roll) begin
          $display("%0t: roll expected %h actual %h", $realtime, want.roll, got.roll);
          errors++;
        end
        if (got.pitch !== want.pitch) begin
          $display("%0t: pitch expected %h actual %h", $realtime, want.pitch, got.pitch);
          errors++;
        end
        if (got.roll_undef !== want.roll_undef) begin
          $display("%0t: roll_undefined expected %b actual %b", $realtime,
                   want.roll_undef, got.roll_undef);
          errors++;
        end
        if (got.pitch_undef !== want.pitch_undef) begin
          $display("%0t: pitch_undefined expected %b actual %b", $realtime,
                   want.pitch_undef, got.pitch_undef);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("accel_tilt_roll_pitch_top: mismatch");
      $finish;
    end
  end

  initial begin
    off_x = 1219;
    off_y = -122;
    off_z = 569;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_offsets();
    test_zero_offsets();
    test_extreme_offsets();
    test_random_offsets();
    test_backpressure();
    test_full_rate();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending_angles.size() == 0) begin
      $display("accel_tilt_roll_pitch_top: match");
    end else begin
      $display("accel_tilt_roll_pitch_top: mismatch");
    end
    $finish;
  end
endmodule

>>> accel_tilt_roll_pitch_top.f
design/atrp_pkg.sv
design/atrp_sqrt_cell.sv
design/atrp_cordic_cell.sv
design/atrp_lane.sv
design/accel_tilt_roll_pitch_top.sv
verif/accel_tilt_roll_pitch_top_tb.sv
